// ===== rtl/min_priority_queue_with_erase_unit_macros.svh =====
// Assertion macros shared by the checker of the priority queue.
`ifndef MIN_PRIORITY_QUEUE_WITH_ERASE_UNIT_MACROS_SVH
`define MIN_PRIORITY_QUEUE_WITH_ERASE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MPQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");
// Next-cycle implication checked outside reset.
`define MPQ_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`endif

// ===== rtl/mpqe_pkg.sv =====
// Package with types and constants of the priority queue with erase.
package mpqe_pkg;
  localparam int unsigned Capacity = 1024;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic signed [31:0] min_key;
    logic               is_empty;
    logic [1:0]         status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_HEAD_RD, S_DONE
  } state_e;
endpackage

// ===== rtl/mpqe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module mpqe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/min_priority_queue_with_erase_unit.sv =====
// Top level of the sorted-store priority queue with erase.
// The done_o strobe follows acceptance via S_HEAD_RD and S_DONE for clear, no-op and a full insert;
// insert and erase first run a binary search of at most ceil(log2(count+1)) steps in S_SRCH_RD and
// S_SRCH_CMP, then move entries in S_SHIFT_RD and S_SHIFT_WR (a missing key moves nothing).
// One transaction at a time; busy is low in the strobe cycle, so a new request can be accepted then.
// Reset clears the count and control asynchronously; the store itself needs no clearing.
module min_priority_queue_with_erase_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  mpqe_pkg::req_t req_i,
  output logic          done_o,
  output mpqe_pkg::rsp_t rsp_o
);
  import mpqe_pkg::*;

  // The store is kept in ascending order in entries below the count, so the
  // minimum is always entry zero. Insert and erase locate the first entry not
  // below the key by binary search and then move the tail one entry at a time.
  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CountW-1:0] idx_q, idx_d;
  cmd_e              cmd_q, cmd_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] min_q, min_d;
  status_e           st_q, st_d;
  logic              done_q, done_d;

  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  logic [31:0]       wdata, rdata;
  logic [CountW-1:0] mid;

  mpqe_ram #(.Width(32), .Depth(Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    idx_q <= idx_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    min_q <= min_d;
    st_q  <= st_d;
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    lo_d = lo_q; hi_d = hi_q; idx_d = idx_q;
    cmd_d = cmd_q; key_d = key_q; min_d = min_q; st_d = st_q;
    done_d = 1'b0;
    we = 1'b0;
    waddr = idx_q[AddrW-1:0];
    wdata = key_q;
    raddr = mid[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d = cmd_e'(req_i.cmd);
          key_d = req_i.key;
          st_d  = ST_OK;
          lo_d  = '0;
          hi_d  = count_q;
          state_d = S_HEAD_RD;
          unique case (cmd_e'(req_i.cmd))
            CMD_INSERT: begin
              if (count_q >= CountW'(Capacity)) st_d = ST_FULL;
              else state_d = S_SRCH_RD;
            end
            CMD_ERASE: state_d = S_SRCH_RD;
            CMD_CLEAR: count_d = '0;
            CMD_NOP: ;
            default: ;
          endcase
        end
      end
      S_SRCH_RD: begin
        // Read at mid is issued this cycle; a finished search reads the hit.
        if (lo_q < hi_q) state_d = S_SRCH_CMP;
        else begin
          raddr = lo_q[AddrW-1:0];
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (lo_q < hi_q) begin
          if ($signed(rdata) < key_q) lo_d = mid + 1'b1;
          else hi_d = mid;
          state_d = S_SRCH_RD;
        end else if (cmd_q == CMD_INSERT) begin
          // Move entries count-1 down to lo up by one, then write the key.
          idx_d = count_q;
          state_d = S_SHIFT_RD;
        end else if (lo_q >= count_q || $signed(rdata) != key_q) begin
          st_d = ST_MISSING;
          state_d = S_HEAD_RD;
        end else begin
          idx_d = lo_q;
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (cmd_q == CMD_INSERT) begin
          if (idx_q == lo_q) begin
            we = 1'b1;
            count_d = count_q + 1'b1;
            state_d = S_HEAD_RD;
          end else begin
            raddr = AddrW'(idx_q - 1'b1);
            state_d = S_SHIFT_WR;
          end
        end else begin
          if (idx_q + 1'b1 >= count_q) begin
            count_d = count_q - 1'b1;
            state_d = S_HEAD_RD;
          end else begin
            raddr = AddrW'(idx_q + 1'b1);
            state_d = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        wdata = rdata;
        if (cmd_q == CMD_INSERT) idx_d = idx_q - 1'b1;
        else idx_d = idx_q + 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_HEAD_RD: begin
        raddr = '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        min_d = rdata;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o.is_empty = (count_q == '0);
  assign rsp_o.min_key  = (count_q == '0) ? 32'sd0 : min_q;
  assign rsp_o.status   = st_q;
endmodule

// ===== rtl/mpqe_checker.sv =====
// Port-level checker for the priority queue, bound to the top level.
`include "min_priority_queue_with_erase_unit_macros.svh"
module mpqe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input mpqe_pkg::rsp_t rsp_o
);
  import mpqe_pkg::*;
  `MPQ_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `MPQ_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, !busy)
  `MPQ_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, done_o && rsp_o.is_empty, rsp_o.min_key == 32'sd0)
  `MPQ_ASSERT_IMP(a_status_ok, clk_i, rst_ni, done_o, rsp_o.status != ST_UNUSED)
  `MPQ_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
endmodule

bind min_priority_queue_with_erase_unit mpqe_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .rsp_o
);
